// File: src/rppo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppo_pkg
// Shared types and constants of the RGB pixel point operation core: request
// and result structs, configuration bundle, mode codes and fixed-point weights.
// ----------------------------------------------------------------------------
package rppo_pkg;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } pixel_out_t;

    typedef struct packed {
        logic        [2:0]  mode;
        logic signed [23:0] modifier;
    } cfg_t;

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_DIV  = 3'd3;
    localparam logic [2:0] MODE_MEAN = 3'd4;
    localparam logic [2:0] MODE_LUMA = 3'd5;

    localparam logic CFG_MODE     = 1'b0;
    localparam logic CFG_MODIFIER = 1'b1;

    localparam int QUOT_BITS    = 9;
    localparam int CHAN_LATENCY = QUOT_BITS + 2;
    localparam int GRAY_STAGES  = 3;
    localparam int GRAY_DELAY   = CHAN_LATENCY - GRAY_STAGES;

    localparam logic [15:0] LUMA_WR     = 16'd19595;
    localparam logic [15:0] LUMA_WG     = 16'd38470;
    localparam logic [15:0] LUMA_WB     = 16'd7471;
    localparam logic [24:0] LUMA_ROUND  = 25'd32768;
    localparam logic [11:0] MEAN_RECIP  = 12'd2731;
    localparam int          MEAN_SHIFT  = 14;

endpackage

// File: src/rppo_chan_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppo_chan_pipe
// Per-channel arithmetic pipeline: add, subtract and multiply by the Q16.8
// modifier, and a restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module rppo_chan_pipe (
    input  logic             clk,
    input  logic             en,
    input  rppo_pkg::cfg_t   cfg,
    input  logic [7:0]       chan,
    output logic [7:0]       res
);

    logic signed [32:0] c_ext;
    logic signed [32:0] m_ext;
    logic signed [32:0] base;
    logic signed [32:0] prod;
    logic signed [32:0] t_next;
    logic        [24:0] n_next;
    logic        [24:0] divisor;

    logic        [7:0]  c_reg [rppo_pkg::QUOT_BITS+1];
    logic signed [32:0] t_reg [rppo_pkg::QUOT_BITS+1];
    logic        [24:0] r_reg [rppo_pkg::QUOT_BITS+1];
    logic [rppo_pkg::QUOT_BITS-1:0] q_reg [rppo_pkg::QUOT_BITS+1];

    logic        [7:0]  res_next;
    logic        [7:0]  res_reg;
    logic signed [32:0] t_fin;
    logic        [32:0] rnd;
    logic        [7:0]  sat_val;
    logic        [7:0]  div_val;

    assign c_ext   = {25'd0, chan};
    assign m_ext   = {{9{cfg.modifier[23]}}, cfg.modifier};
    assign base    = {17'd0, chan, 8'd0};
    assign prod    = c_ext * m_ext;
    assign n_next  = {8'd0, chan, 9'd0} + {cfg.modifier[23], cfg.modifier};
    assign divisor = {cfg.modifier, 1'b0};

    always_comb
    begin
        case (cfg.mode)
            rppo_pkg::MODE_ADD: t_next = base + m_ext;
            rppo_pkg::MODE_SUB: t_next = base - m_ext;
            rppo_pkg::MODE_MUL: t_next = prod;
            default:            t_next = '0;
        endcase
    end

    // operand stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0] <= chan;
            t_reg[0] <= t_next;
            r_reg[0] <= n_next;
            q_reg[0] <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < rppo_pkg::QUOT_BITS; k++)
    begin : g_div
        localparam int BIT = rppo_pkg::QUOT_BITS - 1 - k;
        logic [33:0] dsh;
        logic [33:0] rem;
        logic [33:0] diff;
        logic        fits;

        assign dsh  = {9'd0, divisor} << BIT;
        assign rem  = {9'd0, r_reg[k]};
        assign diff = rem - dsh;
        assign fits = (rem >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_reg[k+1] <= c_reg[k];
                t_reg[k+1] <= t_reg[k];
                r_reg[k+1] <= fits ? diff[24:0] : r_reg[k];
                q_reg[k+1] <= q_reg[k] | (fits ? (rppo_pkg::QUOT_BITS)'(1) << BIT
                                              : (rppo_pkg::QUOT_BITS)'(0));
            end
        end
    end

    // round half up and saturate
    assign t_fin = t_reg[rppo_pkg::QUOT_BITS];
    assign rnd   = t_fin + 33'sd128;

    always_comb
    begin
        if (t_fin[32])
            sat_val = 8'd0;
        else if (|rnd[32:16])
            sat_val = 8'd255;
        else
            sat_val = rnd[15:8];
    end

    always_comb
    begin
        if (cfg.modifier == 24'sd0)
            div_val = c_reg[rppo_pkg::QUOT_BITS];
        else if (cfg.modifier[23])
            div_val = 8'd0;
        else if (q_reg[rppo_pkg::QUOT_BITS][rppo_pkg::QUOT_BITS-1])
            div_val = 8'd255;
        else
            div_val = q_reg[rppo_pkg::QUOT_BITS][7:0];
    end

    always_comb
    begin
        case (cfg.mode) inside
            rppo_pkg::MODE_ADD, rppo_pkg::MODE_SUB, rppo_pkg::MODE_MUL:
                res_next = sat_val;
            rppo_pkg::MODE_DIV:
                res_next = div_val;
            default:
                res_next = c_reg[rppo_pkg::QUOT_BITS];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: src/rppo_gray_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppo_gray_pipe
// Gray value pipeline: channel mean via reciprocal multiply and fixed-point
// luma, delayed to line up with the channel pipelines.
// ----------------------------------------------------------------------------
module rppo_gray_pipe (
    input  logic                 clk,
    input  logic                 en,
    input  rppo_pkg::cfg_t       cfg,
    input  rppo_pkg::pixel_in_t  pix,
    output logic [7:0]           gray
);

    logic [9:0]  sum_reg;
    logic [23:0] pr_reg;
    logic [23:0] pg_reg;
    logic [23:0] pb_reg;
    logic [10:0] mean_num;
    logic [22:0] mean_prod_reg;
    logic [24:0] luma_sum_reg;
    logic [7:0]  y_next;
    logic [7:0]  y_reg;
    logic [7:0]  dly_reg [rppo_pkg::GRAY_DELAY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= 10'(pix.in_red) + 10'(pix.in_green) + 10'(pix.in_blue);
            pr_reg  <= 24'(pix.in_red)   * 24'(rppo_pkg::LUMA_WR);
            pg_reg  <= 24'(pix.in_green) * 24'(rppo_pkg::LUMA_WG);
            pb_reg  <= 24'(pix.in_blue)  * 24'(rppo_pkg::LUMA_WB);
        end
    end

    // (2*sum + 3) / 6 as multiply by reciprocal
    assign mean_num = {sum_reg, 1'b0} + 11'd3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mean_prod_reg <= 23'(mean_num) * 23'(rppo_pkg::MEAN_RECIP);
            luma_sum_reg  <= 25'(pr_reg) + 25'(pg_reg) + 25'(pb_reg)
                           + rppo_pkg::LUMA_ROUND;
        end
    end

    always_comb
    begin
        if (cfg.mode == rppo_pkg::MODE_LUMA)
            y_next = luma_sum_reg[24] ? 8'd255 : luma_sum_reg[23:16];
        else
            y_next = mean_prod_reg[rppo_pkg::MEAN_SHIFT+7:rppo_pkg::MEAN_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    // align with channel pipeline depth
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= y_reg;
            for (int i = 1; i < rppo_pkg::GRAY_DELAY; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    assign gray = dly_reg[rppo_pkg::GRAY_DELAY-1];

endmodule

// File: src/rppo_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppo_out_skid
// Output register with one skid entry; holds the pipeline while the skid
// entry is occupied so that no result is lost when the receiver stalls.
// ----------------------------------------------------------------------------
module rppo_out_skid (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rppo_pkg::pixel_out_t  push_data,
    output logic                  full,
    output logic                  result_valid,
    input  logic                  result_ready,
    output rppo_pkg::pixel_out_t  result
);

    logic                 main_valid_reg;
    logic                 skid_valid_reg;
    rppo_pkg::pixel_out_t main_reg;
    rppo_pkg::pixel_out_t skid_reg;
    logic                 main_free;

    assign main_free = ~main_valid_reg | result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg | push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        else if (push)
            skid_reg <= push_data;
    end

    assign full         = skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result       = main_reg;

endmodule

// File: src/rgb_pixel_point_operation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pixel_point_operation_core
// Point operation on RGB pixels: add, subtract, multiply or divide each channel
// by a signed Q16.8 modifier, or convert to gray by channel mean or luma.
//
// Usage:
//   pixel requests enter on pixel_valid/pixel_ready, processed pixels leave on
//   result_valid/result_ready, one result per request, in order
//   mode and modifier are written through cfg_we/cfg_index/cfg_data (index 0
//   mode, index 1 modifier); the user must write them only while the core is
//   idle, since the core itself does not enforce this
//   one request per cycle is accepted while the receiver keeps up
//   depth is set by the divider, one quotient bit per pipeline stage
//   when the receiver stalls, the result waits in the output register, one more
//   result goes into the skid entry, and then pixel_ready falls until it drains
//   reset clears all valid bits and sets mode and modifier to zero
// ----------------------------------------------------------------------------
module rgb_pixel_point_operation_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [23:0]           cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  rppo_pkg::pixel_in_t   pixel,
    output logic                  result_valid,
    input  logic                  result_ready,
    output rppo_pkg::pixel_out_t  result
);

    logic [2:0]           mode_reg;
    logic signed [23:0]   modifier_reg;
    rppo_pkg::cfg_t       cfg;
    logic                 en;
    logic                 full;
    logic                 vld_reg [rppo_pkg::CHAN_LATENCY];
    logic [7:0]           red_res;
    logic [7:0]           green_res;
    logic [7:0]           blue_res;
    logic [7:0]           gray;
    logic                 gray_mode;
    rppo_pkg::pixel_out_t push_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= rppo_pkg::MODE_ADD;
            modifier_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rppo_pkg::CFG_MODE:     mode_reg     <= cfg_data[2:0];
                rppo_pkg::CFG_MODIFIER: modifier_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    assign cfg.mode     = mode_reg;
    assign cfg.modifier = modifier_reg;

    assign en          = ~full;
    assign pixel_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rppo_pkg::CHAN_LATENCY; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= pixel_valid;
            for (int i = 1; i < rppo_pkg::CHAN_LATENCY; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    rppo_chan_pipe u_red (
        .clk  (clk),
        .en   (en),
        .cfg  (cfg),
        .chan (pixel.in_red),
        .res  (red_res)
    );

    rppo_chan_pipe u_green (
        .clk  (clk),
        .en   (en),
        .cfg  (cfg),
        .chan (pixel.in_green),
        .res  (green_res)
    );

    rppo_chan_pipe u_blue (
        .clk  (clk),
        .en   (en),
        .cfg  (cfg),
        .chan (pixel.in_blue),
        .res  (blue_res)
    );

    rppo_gray_pipe u_gray (
        .clk  (clk),
        .en   (en),
        .cfg  (cfg),
        .pix  (pixel),
        .gray (gray)
    );

    assign gray_mode = (mode_reg == rppo_pkg::MODE_MEAN) || (mode_reg == rppo_pkg::MODE_LUMA);

    always_comb
    begin
        if (gray_mode)
        begin
            push_data.out_red   = gray;
            push_data.out_green = gray;
            push_data.out_blue  = gray;
        end
        else
        begin
            push_data.out_red   = red_res;
            push_data.out_green = green_res;
            push_data.out_blue  = blue_res;
        end
    end

    rppo_out_skid u_skid (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (en & vld_reg[rppo_pkg::CHAN_LATENCY-1]),
        .push_data    (push_data),
        .full         (full),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: dv/tb_rgb_pixel_point_operation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_pixel_point_operation_core
// Self-checking bench for the RGB pixel point operation core. Directed
// requests cover each mode, the field extremes, rounding, clamping,
// saturation, division by zero and the spare mode codes. Random traffic then
// runs under several mode and modifier settings and varying handshake
// pressure. A local pixel predictor builds the expected results, and these are
// compared field by field, in order, with what the core returns.
// ----------------------------------------------------------------------------
module tb_rgb_pixel_point_operation_core;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int         STALL_LIMIT   = 1000;
    localparam int         HOLD_OFF_LEN  = 80;
    localparam int         GROUP_SIZE    = 22;
    localparam int         MAX_REPORTS   = 50;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [23:0]          cfg_data;
    logic                 pixel_valid;
    logic                 pixel_ready;
    rppo_pkg::pixel_in_t  pixel;
    logic                 result_valid;
    logic                 result_ready;
    rppo_pkg::pixel_out_t result;

    rppo_pkg::cfg_t       shadow_cfg = '0;
    rppo_pkg::pixel_out_t expected_pixels[$];
    int         error_count   = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_off_left = 0;
    int         idle_cycles   = 0;

    rgb_pixel_point_operation_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // pixel predictor
    function automatic logic [7:0] round_sat_q8(input longint t);
        longint r;
        if (t < 0)
            return 8'd0;
        r = (t + 128) >> 8;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic logic [7:0] channel_op(input logic [7:0] c, input logic [2:0] mode,
                                              input logic signed [23:0] modifier);
        longint v;
        longint m;
        longint q;
        v = longint'(c);
        m = longint'(modifier);
        case (mode)
            rppo_pkg::MODE_ADD: return round_sat_q8(v * 256 + m);
            rppo_pkg::MODE_SUB: return round_sat_q8(v * 256 - m);
            rppo_pkg::MODE_MUL: return round_sat_q8(v * m);
            rppo_pkg::MODE_DIV:
            begin
                if (m == 0)
                    return c;
                if (m < 0)
                    return 8'd0;
                q = (2 * v * 256 + m) / (2 * m);
                return (q > 255) ? 8'd255 : q[7:0];
            end
            default: return c;
        endcase
    endfunction

    function automatic rppo_pkg::pixel_out_t point_op_expected(input rppo_pkg::pixel_in_t px,
                                                               input rppo_pkg::cfg_t c);
        rppo_pkg::pixel_out_t o;
        longint               y;
        if (c.mode == rppo_pkg::MODE_MEAN || c.mode == rppo_pkg::MODE_LUMA)
        begin
            if (c.mode == rppo_pkg::MODE_MEAN)
                y = (2 * (longint'(px.in_red) + longint'(px.in_green)
                     + longint'(px.in_blue)) + 3) / 6;
            else
                y = (longint'(rppo_pkg::LUMA_WR) * px.in_red
                     + longint'(rppo_pkg::LUMA_WG) * px.in_green
                     + longint'(rppo_pkg::LUMA_WB) * px.in_blue
                     + longint'(rppo_pkg::LUMA_ROUND)) >> 16;
            if (y > 255)
                y = 255;
            o.out_red   = y[7:0];
            o.out_green = y[7:0];
            o.out_blue  = y[7:0];
        end
        else
        begin
            o.out_red   = channel_op(px.in_red,   c.mode, c.modifier);
            o.out_green = channel_op(px.in_green, c.mode, c.modifier);
            o.out_blue  = channel_op(px.in_blue,  c.mode, c.modifier);
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        if (error_count < MAX_REPORTS)
            $display("ERROR at %0t ns: %s expected %0d got %0d", $time, what, exp_v, got_v);
        error_count++;
    endtask

    // request and result tracking
    always @(posedge clk)
    begin
        rppo_pkg::pixel_out_t exp_px;
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
                expected_pixels.push_back(point_op_expected(pixel, shadow_cfg));
            if (result_valid && result_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("result with no request pending", 0, int'(result));
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    if (result.out_red != exp_px.out_red)
                        report_mismatch("out_red", exp_px.out_red, result.out_red);
                    if (result.out_green != exp_px.out_green)
                        report_mismatch("out_green", exp_px.out_green, result.out_green);
                    if (result.out_blue != exp_px.out_blue)
                        report_mismatch("out_blue", exp_px.out_blue, result.out_blue);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver with random stalls and long hold-off
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                result_ready <= 1'b0;
                hold_off_left--;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_pixel(input rppo_pkg::pixel_in_t px);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
    endtask

    task automatic drain_requests();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == rppo_pkg::CFG_MODE)
            shadow_cfg.mode = data[2:0];
        else
            shadow_cfg.modifier = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [2:0] mode, input logic [23:0] modifier);
        logic [20:0] junk;
        drain_requests();
        junk = $urandom_range(1) ? 21'($urandom) : '0;
        write_reg(rppo_pkg::CFG_MODE, {junk, mode});
        write_reg(rppo_pkg::CFG_MODIFIER, modifier);
    endtask

    function automatic logic [7:0] random_channel();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(3));
            3: return 8'(252 + $urandom_range(3));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [23:0] random_modifier();
        int v;
        case ($urandom_range(4))
            0: v = int'($urandom);
            1: v = int'($urandom_range(2048)) - 1024;
            2:
            begin
                case ($urandom_range(4))
                    0: v = 24'h7fffff;
                    1: v = 24'h800000;
                    2: v = 0;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
            3: v = (int'($urandom_range(32)) - 16) * 128;
            default: v = int'($urandom_range(4096, 1));
        endcase
        return v[23:0];
    endfunction

    // reset values give add with a zero modifier, so pixels pass unchanged
    task automatic test_reset_state();
        send_pixel('{8'd0, 8'd128, 8'd255});
        send_pixel('{8'd255, 8'd1, 8'd254});
    endtask

    task automatic test_add_subtract();
        set_config(rppo_pkg::MODE_ADD, 24'h7fffff);
        send_pixel('{8'd255, 8'd0, 8'd127});
        set_config(rppo_pkg::MODE_ADD, 24'h800000);
        send_pixel('{8'd255, 8'd0, 8'd127});
        set_config(rppo_pkg::MODE_ADD, 24'd128);
        send_pixel('{8'd0, 8'd1, 8'd254});
        set_config(rppo_pkg::MODE_SUB, 24'd128);
        send_pixel('{8'd0, 8'd1, 8'd255});
        set_config(rppo_pkg::MODE_SUB, 24'h800000);
        send_pixel('{8'd0, 8'd200, 8'd255});
    endtask

    task automatic test_multiply_divide();
        set_config(rppo_pkg::MODE_MUL, -24'sd256);
        send_pixel('{8'd0, 8'd100, 8'd255});
        set_config(rppo_pkg::MODE_MUL, 24'd384);
        send_pixel('{8'd1, 8'd3, 8'd255});
        // divide by zero passes the pixel through
        set_config(rppo_pkg::MODE_DIV, 24'd0);
        send_pixel('{8'd7, 8'd128, 8'd250});
        set_config(rppo_pkg::MODE_DIV, -24'sd256);
        send_pixel('{8'd0, 8'd9, 8'd255});
        set_config(rppo_pkg::MODE_DIV, 24'd1);
        send_pixel('{8'd0, 8'd1, 8'd255});
        set_config(rppo_pkg::MODE_DIV, 24'd768);
        send_pixel('{8'd1, 8'd2, 8'd255});
        set_config(rppo_pkg::MODE_DIV, 24'h7fffff);
        send_pixel('{8'd255, 8'd128, 8'd0});
    endtask

    task automatic test_gray_modes();
        set_config(rppo_pkg::MODE_MEAN, random_modifier());
        send_pixel('{8'd255, 8'd255, 8'd255});
        send_pixel('{8'd0, 8'd0, 8'd1});
        send_pixel('{8'd0, 8'd1, 8'd1});
        set_config(rppo_pkg::MODE_LUMA, random_modifier());
        send_pixel('{8'd255, 8'd255, 8'd255});
        send_pixel('{8'd0, 8'd0, 8'd0});
        send_pixel('{8'd1, 8'd0, 8'd0});
    endtask

    task automatic test_unused_modes();
        set_config(MODE_SPARE_LO, 24'h7fffff);
        send_pixel('{8'd3, 8'd200, 8'd255});
        set_config(MODE_SPARE_HI, 24'h800000);
        send_pixel('{8'd0, 8'd77, 8'd254});
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        int sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count)
        begin
            set_config(3'($urandom_range(7)), random_modifier());
            repeat (GROUP_SIZE)
            begin
                send_pixel('{random_channel(), random_channel(), random_channel()});
                sent++;
            end
        end
        drain_requests();
    endtask

    // long receiver hold-off so the core fills and stalls its input
    task automatic test_output_backpressure();
        set_config(rppo_pkg::MODE_DIV, random_modifier());
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = HOLD_OFF_LEN;
        repeat (40)
            send_pixel('{random_channel(), random_channel(), random_channel()});
        drain_requests();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = rppo_pkg::CFG_MODE;
        cfg_data    = '0;
        pixel_valid = 1'b0;
        pixel       = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_add_subtract();
        test_multiply_divide();
        test_gray_modes();
        test_unused_modes();
        test_random_traffic(24, 88, 550);
        test_random_traffic(88, 24, 550);
        test_random_traffic(0, 0, 550);
        test_output_backpressure();

        drain_requests();
        repeat (rppo_pkg::CHAN_LATENCY + 4) @(posedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch("results never returned", 0, expected_pixels.size());
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
